// ----- design/pge_pkg.sv -----
// shared types, constants and log table for the gene entropy block
package pge_pkg;

  localparam int MAX_MACHINES = 16;
  localparam int MAX_JOBS     = 32;
  localparam int MAX_POP      = 256;
  localparam int FRAC_BITS    = 16;

  localparam int MACH_W      = 4;
  localparam int POS_W       = 5;
  localparam int JOB_W       = 5;
  localparam int ADDR_W      = MACH_W + POS_W + JOB_W;
  localparam int STORE_DEPTH = MAX_MACHINES * MAX_JOBS * MAX_JOBS;
  localparam int COUNT_W     = 9;
  localparam int LOG_W       = 20;
  localparam int ACC_W       = 48;
  localparam int DVS_W       = 20;
  localparam int STEP_W      = 6;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [LOG_W-1:0]   LOG_POP_MAX = LOG_W'(8 << FRAC_BITS);

  // configuration register indexes
  localparam logic [1:0] REG_NUM_MACHINES = 2'd0;
  localparam logic [1:0] REG_NUM_JOBS     = 2'd1;
  localparam logic [1:0] REG_POP_SIZE     = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CHECK, ST_JDIV, ST_RD, ST_RMW, ST_WSTART, ST_WRD,
    ST_WEV, ST_TERM, ST_DFREQ, ST_DNORM, ST_WNEXT, ST_DMEAN, ST_FOUT
  } state_t;

  typedef enum logic [1:0] {DIV_JOB, DIV_FREQ, DIV_NORM, DIV_MEAN} div_sel_t;

  typedef struct packed {
    logic     capture;
    logic     err_set;
    logic     clear_step;
    logic     div_start;
    div_sel_t div_sel;
    logic     rd_walk;
    logic     wr_item;
    logic     wr_zero;
    logic     walk_init;
    logic     lc_load;
    logic     acc_add;
    logic     walk_step;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic item_bad;
    logic item_last;
    logic div_done;
    logic term_needed;
    logic walk_last;
    logic out_free;
  } sts_t;

  typedef logic [LOG_W-1:0] log_tab_t [256];

  // log2 in fixed point, fraction by repeated squaring of a Q1.30 mantissa
  function automatic logic [LOG_W-1:0] log2_fx(input int unsigned x);
    logic [63:0]         m;
    int unsigned         ip;
    logic [FRAC_BITS-1:0] frac;
    ip = 0;
    frac = '0;
    for (int i = 0; i < 8; i++) begin
      if ((x >> ip) > 1) ip++;
    end
    m = (64'(x) << 30) >> ip;
    for (int i = 0; i < FRAC_BITS; i++) begin
      m = (m * m) >> 30;
      frac = {frac[FRAC_BITS-2:0], 1'b0};
      if (m >= (64'd1 << 31)) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    if (x == 0) return '0;
    return {4'(ip), frac};
  endfunction

  function automatic log_tab_t make_log_table();
    log_tab_t t;
    for (int i = 0; i < 256; i++) t[i] = log2_fx(i);
    return t;
  endfunction

  localparam log_tab_t LOG_TABLE = make_log_table();

endpackage

// ----- design/pge_ram.sv -----
// generic single write, single read ram with registered read
module pge_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- design/pge_div.sv -----
// serial restoring divider, one quotient bit per cycle
module pge_div import pge_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ACC_W-1:0]  dividend,
  input  logic [DVS_W-1:0]  divisor,
  input  logic [STEP_W-1:0] steps,
  output logic [ACC_W-1:0]  quotient,
  output logic              done
);

  logic [ACC_W-1:0]  dvd;
  logic [DVS_W-1:0]  dvs;
  logic [DVS_W-1:0]  rem;
  logic [STEP_W-1:0] k;
  logic              busy;
  logic [DVS_W:0]    trial;
  logic              fits;

  // one trial subtraction
  always_comb begin
    trial = {rem, dvd[k]};
    fits  = trial >= {1'b0, dvs};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && k == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      quotient <= '0;
      k        <= steps - STEP_W'(1);
    end else if (busy) begin
      rem         <= fits ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
      quotient[k] <= fits;
      k           <= k - STEP_W'(1);
    end
  end

endmodule

// ----- design/pge_datapath.sv -----
// datapath: config, item capture, count store, walk counters, arithmetic
module pge_datapath import pge_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [8:0]        cfg_data,
  input  logic [MACH_W-1:0] machine,
  input  logic [POS_W-1:0]  position,
  input  logic [9:0]        op_number,
  input  logic              last_item,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [15:0]       entropy,
  output logic              error,
  input  cmd_t              cmd,
  output sts_t              sts
);

  logic [4:0] num_machines;
  logic [5:0] num_jobs;
  logic [8:0] pop_size;
  logic [4:0] nm;
  logic [5:0] nj;
  logic [8:0] pp;
  logic [10:0] grid;

  logic [MACH_W-1:0] mach_q;
  logic [POS_W-1:0]  pos_q;
  logic [9:0]        op_q;
  logic              last_q;
  logic              err;

  logic [MACH_W-1:0] wm;
  logic [POS_W-1:0]  wp;
  logic [JOB_W-1:0]  wj;
  logic              wj_end, wp_end;

  logic [LOG_W-1:0] lp_q, ln_q, lc_q;
  logic [7:0]       c_q;
  logic [ACC_W-1:0] acc;
  logic [27:0]      prod;

  logic [ACC_W-1:0]  dvd;
  logic [DVS_W-1:0]  dvs;
  logic [STEP_W-1:0] steps;
  logic [ACC_W-1:0]  quo;
  logic              div_done;

  logic [ADDR_W-1:0]  clr_cnt;
  logic [ADDR_W-1:0]  item_addr, walk_addr;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [COUNT_W-1:0] ram_wdata, ram_rdata, cnt_inc;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_machines <= 5'd1;
      num_jobs     <= 6'd2;
      pop_size     <= 9'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_MACHINES: num_machines <= cfg_data[4:0];
        REG_NUM_JOBS:     num_jobs     <= cfg_data[5:0];
        REG_POP_SIZE:     pop_size     <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped settings
  always_comb begin
    nm = (num_machines == '0) ? 5'd1 :
         (num_machines > 5'(MAX_MACHINES)) ? 5'(MAX_MACHINES) : num_machines;
    nj = (num_jobs < 6'd2) ? 6'd2 :
         (num_jobs > 6'(MAX_JOBS)) ? 6'(MAX_JOBS) : num_jobs;
    pp = (pop_size == '0) ? 9'd1 :
         (pop_size > 9'(MAX_POP)) ? 9'(MAX_POP) : pop_size;
    grid = 11'(nm) * 11'(nj);
  end

  // input beat capture and error flag
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mach_q <= machine;
      pos_q  <= position;
      op_q   <= op_number;
      last_q <= last_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) err <= 1'b0;
    else if (cmd.err_set) err <= 1'b1;
    else if (cmd.out_load) err <= 1'b0;
  end

  // walk counters over machine, position, job
  assign wj_end = ({1'b0, wj} == nj - 6'd1);
  assign wp_end = ({1'b0, wp} == nj - 6'd1);

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      wm <= '0;
      wp <= '0;
      wj <= '0;
    end else if (cmd.walk_step) begin
      if (wj_end) begin
        wj <= '0;
        if (wp_end) begin
          wp <= '0;
          wm <= wm + MACH_W'(1);
        end else begin
          wp <= wp + POS_W'(1);
        end
      end else begin
        wj <= wj + JOB_W'(1);
      end
    end
  end

  // log values and accumulator
  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      lp_q <= (pp == 9'(MAX_POP)) ? LOG_POP_MAX : LOG_TABLE[pp[7:0]];
      ln_q <= LOG_TABLE[8'(nj)];
    end
    if (cmd.lc_load) begin
      c_q  <= ram_rdata[7:0];
      lc_q <= LOG_TABLE[ram_rdata[7:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_init) acc <= '0;
    else if (cmd.acc_add) acc <= acc + quo;
  end

  // divider operand selection
  assign prod = 28'(c_q) * 28'(lp_q - lc_q);

  always_comb begin
    case (cmd.div_sel)
      DIV_JOB: begin
        dvd   = ACC_W'(op_q - 10'd1);
        dvs   = DVS_W'(nm);
        steps = STEP_W'(10);
      end
      DIV_FREQ: begin
        dvd   = ACC_W'(prod);
        dvs   = DVS_W'(pp);
        steps = STEP_W'(28);
      end
      DIV_NORM: begin
        dvd   = ACC_W'({quo[19:0], 16'b0});
        dvs   = ln_q;
        steps = STEP_W'(36);
      end
      default: begin
        dvd   = acc;
        dvs   = DVS_W'(grid);
        steps = STEP_W'(ACC_W);
      end
    endcase
  end

  pge_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .steps    (steps),
    .quotient (quo),
    .done     (div_done)
  );

  // clearing pass counter after reset
  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clear_step) clr_cnt <= clr_cnt + ADDR_W'(1);
  end

  // count store access
  assign item_addr = {mach_q, pos_q, quo[JOB_W-1:0]};
  assign walk_addr = {wm, wp, wj};
  assign cnt_inc   = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + COUNT_W'(1);

  always_comb begin
    ram_we    = cmd.clear_step || cmd.wr_item || cmd.wr_zero;
    ram_waddr = clr_cnt;
    ram_wdata = '0;
    if (cmd.wr_item) begin
      ram_waddr = item_addr;
      ram_wdata = cnt_inc;
    end else if (cmd.wr_zero) begin
      ram_waddr = walk_addr;
    end
    ram_raddr = cmd.rd_walk ? walk_addr : item_addr;
  end

  pge_ram #(.WIDTH(COUNT_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      entropy <= (|quo[ACC_W-1:16]) ? 16'hFFFF : quo[15:0];
      error   <= err;
    end
  end

  // status back to the controller
  always_comb begin
    sts.clear_last  = (clr_cnt == '1);
    sts.item_bad    = ({1'b0, mach_q} >= nm) || ({1'b0, pos_q} >= nj) ||
                      (op_q == '0) || (11'(op_q) > grid);
    sts.item_last   = last_q;
    sts.div_done    = div_done;
    sts.term_needed = (ram_rdata != '0) && (ram_rdata < pp);
    sts.walk_last   = wj_end && wp_end && ({1'b0, wm} == nm - 5'd1);
    sts.out_free    = !out_valid || out_ready;
  end

endmodule

// ----- design/pge_ctrl.sv -----
// controller state machine sequencing load, walk and result
module pge_ctrl import pge_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (sts.clear_last) state_next = ST_IDLE;
      ST_IDLE:   if (in_valid) state_next = ST_CHECK;
      ST_CHECK: begin
        if (!sts.item_bad) state_next = ST_JDIV;
        else if (sts.item_last) state_next = ST_WSTART;
        else state_next = ST_IDLE;
      end
      ST_JDIV:   if (sts.div_done) state_next = ST_RD;
      ST_RD:     state_next = ST_RMW;
      ST_RMW:    state_next = sts.item_last ? ST_WSTART : ST_IDLE;
      ST_WSTART: state_next = ST_WRD;
      ST_WRD:    state_next = ST_WEV;
      ST_WEV:    state_next = sts.term_needed ? ST_TERM : ST_WNEXT;
      ST_TERM:   state_next = ST_DFREQ;
      ST_DFREQ:  if (sts.div_done) state_next = ST_DNORM;
      ST_DNORM:  if (sts.div_done) state_next = ST_WNEXT;
      ST_WNEXT:  state_next = sts.walk_last ? ST_DMEAN : ST_WRD;
      ST_DMEAN:  if (sts.div_done) state_next = ST_FOUT;
      ST_FOUT:   if (sts.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    cmd.div_sel = DIV_JOB;
    in_ready = 1'b0;
    unique case (state)
      ST_CLEAR: cmd.clear_step = 1'b1;
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_CHECK: begin
        cmd.err_set   = sts.item_bad;
        cmd.div_start = !sts.item_bad;
        cmd.div_sel   = DIV_JOB;
      end
      ST_RMW:    cmd.wr_item = 1'b1;
      ST_WSTART: cmd.walk_init = 1'b1;
      ST_WRD:    cmd.rd_walk = 1'b1;
      ST_WEV: begin
        cmd.wr_zero = 1'b1;
        cmd.lc_load = 1'b1;
      end
      ST_TERM: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_FREQ;
      end
      ST_DFREQ: begin
        cmd.div_start = sts.div_done;
        cmd.div_sel   = DIV_NORM;
      end
      ST_DNORM: cmd.acc_add = sts.div_done;
      ST_WNEXT: begin
        cmd.walk_step = !sts.walk_last;
        cmd.div_start = sts.walk_last;
        cmd.div_sel   = DIV_MEAN;
      end
      ST_FOUT: cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

endmodule

// ----- design/population_gene_entropy.sv -----
// Gene entropy of a population of job-shop schedules. After reset all 16384 counters of the
// count store are swept clear, during which no beat is taken (configuration writes still land).
// Each input beat then goes through capture, range check, a serial division of the
// operation number less one by num_machines, and a read-modify-write of one counter in
// the one-write, one-read count memory; an out-of-range beat skips the division and the
// counter write and sets the error flag. A beat marked last starts the walk over
// num_machines*num_jobs*num_jobs counters, using the shared serial divider twice for
// every count that lies strictly between 0 and pop_size, and a final division for the
// mean. The result sits in an output register, so loading of the next population may
// begin while it waits to be taken.
module population_gene_entropy import pge_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  machine,
  input  logic [4:0]  position,
  input  logic [9:0]  op_number,
  input  logic        last_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] entropy,
  output logic        error
);

  cmd_t cmd;
  sts_t sts;

  // sequencing
  pge_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage and arithmetic
  pge_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .machine   (machine),
    .position  (position),
    .op_number (op_number),
    .last_item (last_item),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .entropy   (entropy),
    .error     (error),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- design/pge_checker.sv -----
// port level checks for the gene entropy block, bound to the top level
module pge_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] entropy,
  input logic        error
);

  // a waiting result beat holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(entropy) && $stable(error))
    else $error("result beat changed while stalled");

  // reset leaves no result pending
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // clearing pass blocks input right after reset
  assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input taken during clearing pass");

  // a new result only follows a cycle of busy work
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while input side idle");

endmodule

bind population_gene_entropy pge_checker u_pge_checker (.*);
